### src/ctyr_pkg.sv
// Shared constants, widths and the CORDIC arctangent table for the
// coordinated-turn yaw rate block. No dependencies.
package ctyr_pkg;

	localparam int HALF_PI_Q13  = 12868;
	localparam int MAX_ROLL_Q13 = 11438;
	localparam int PI_Q13       = 25736;
	localparam int GRAV_Q16     = 642689;
	localparam int CORDIC_K_Q30 = 652032874;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = 4;

	localparam int AIRSPEED_LOW_RESET  = 2560;
	localparam int AIRSPEED_HIGH_RESET = 7680;

	// Register indexes.
	localparam logic REG_AIRSPEED_LOW  = 1'b0;
	localparam logic REG_AIRSPEED_HIGH = 1'b1;

	localparam int Z_W   = 21;  // Q.16 angle with headroom
	localparam int XY_W  = 34;  // Q.30 rotation vector
	localparam int TRIG_W = 18; // Q.16 sine and cosine
	localparam int GRAV_W = 21;
	localparam int PROD_W = 2 * TRIG_W;
	localparam int NUM_W  = PROD_W + GRAV_W;
	localparam int DEN_W  = TRIG_W + 17 + 8;
	localparam int DIV_W  = DEN_W - 1;
	localparam int DVD_W  = NUM_W + 1;
	localparam int QUO_W  = 32;

	function automatic logic signed [Z_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] r;
		unique case (i)
			4'd0:    r = Z_W'(51472);
			4'd1:    r = Z_W'(30386);
			4'd2:    r = Z_W'(16055);
			4'd3:    r = Z_W'(8150);
			4'd4:    r = Z_W'(4091);
			4'd5:    r = Z_W'(2047);
			4'd6:    r = Z_W'(1024);
			4'd7:    r = Z_W'(512);
			4'd8:    r = Z_W'(256);
			4'd9:    r = Z_W'(128);
			4'd10:   r = Z_W'(64);
			4'd11:   r = Z_W'(32);
			4'd12:   r = Z_W'(16);
			4'd13:   r = Z_W'(8);
			4'd14:   r = Z_W'(4);
			default: r = Z_W'(2);
		endcase
		return r;
	endfunction

endpackage

### src/coordinated_turn_yaw_rate.sv
// Coordinated-turn yaw rate setpoint: sequencer, shared CORDIC and divider.
// The result is loaded from the done state. A held, inverted or zero-airspeed beat goes there
// from idle; any other beat takes two 16-step CORDIC passes, two multiply states and 32 divide
// steps. An overflowing quotient skips the divide steps, and a divisor that is not positive
// skips the divider. One beat at a time: the input stalls until the result is loaded.
// Reset clears the held rate and restores the limits.
module coordinated_turn_yaw_rate import ctyr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] roll_target,
	input  logic [15:0]        airspeed_meas,
	input  logic               inputs_valid,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] yaw_rate_target,
	output logic               inverted_flight,
	output logic               rate_fault,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROLL  = 3'd1;
	localparam logic [2:0] ST_PITCH = 3'd2;
	localparam logic [2:0] ST_MUL1  = 3'd3;
	localparam logic [2:0] ST_MUL2  = 3'd4;
	localparam logic [2:0] ST_DIVGO = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]  state_q;
	logic [15:0] lo_lim_q, hi_lim_q;
	logic signed [31:0] held_q;
	logic inv_q, fault_q;
	logic out_valid_q, out_inv_q, out_fault_q;
	logic signed [31:0] out_rate_q;

	logic signed [17:0] roll_abs, lim, rc, pa, pitch_abs;
	logic [15:0]        v_clamp;
	logic signed [17:0] pa_q;
	logic               neg_q;
	logic [15:0]        v_q;

	logic signed [TRIG_W-1:0] s_q, cr_q, cp_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [NUM_W-1:0]  num_q;
	logic signed [DEN_W-1:0]  den_q;

	logic                   cor_start, cor_done;
	logic signed [Z_W-1:0]  cor_angle;
	logic signed [XY_W-1:0] cor_cos, cor_sin, cp_full;

	logic             div_start, div_done, div_ovf;
	logic [DVD_W-1:0] dividend;
	logic [NUM_W-1:0] num_mag;
	logic [QUO_W-1:0] quo;
	logic signed [31:0] sat_rate;

	logic accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Roll clamp, pitch reduction and airspeed clamp for the incoming beat.
	always_comb begin
		roll_abs  = roll_angle < 0 ? -18'(roll_angle) : 18'(roll_angle);
		lim       = roll_target < 0 ? -18'(roll_target) : 18'(roll_target);
		rc        = 18'(roll_angle);
		if (rc > 18'(MAX_ROLL_Q13))  rc = 18'(MAX_ROLL_Q13);
		if (rc < -18'(MAX_ROLL_Q13)) rc = -18'(MAX_ROLL_Q13);
		if (rc > lim)  rc = lim;
		if (rc < -lim) rc = -lim;
		pitch_abs = pitch_angle < 0 ? -18'(pitch_angle) : 18'(pitch_angle);
		pa        = pitch_abs > 18'(HALF_PI_Q13) ? 18'(PI_Q13) - pitch_abs : pitch_abs;
		v_clamp   = airspeed_meas;
		if (airspeed_meas < lo_lim_q)      v_clamp = lo_lim_q;
		else if (airspeed_meas > hi_lim_q) v_clamp = hi_lim_q;
	end

	// The pitch cosine is negated before its floor shift.
	assign cp_full = neg_q ? -cor_cos : cor_cos;

	always_comb begin
		cor_start = 1'b0;
		cor_angle = Z_W'(pa_q) <<< 3;
		if (state_q == ST_IDLE) begin
			cor_start = accept && inputs_valid && roll_abs < 18'(HALF_PI_Q13)
				&& v_clamp != 16'd0;
			cor_angle = Z_W'(rc) <<< 3;
		end else if (state_q == ST_ROLL) begin
			cor_start = cor_done;
		end
	end

	assign num_mag   = num_q < 0 ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign dividend  = DVD_W'(num_mag) + DVD_W'(den_q[DEN_W-1:1]);
	assign div_start = (state_q == ST_DIVGO) && den_q > 0;

	always_comb begin
		if (num_q < 0) begin
			if (div_ovf || quo > 32'h8000_0000) sat_rate = 32'sh8000_0000;
			else sat_rate = -$signed(quo);
		end else begin
			if (div_ovf || quo > 32'h7FFF_FFFF) sat_rate = 32'sh7FFF_FFFF;
			else sat_rate = $signed(quo);
		end
	end

	ctyr_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (cor_angle),
		.done    (cor_done),
		.cos_val (cor_cos),
		.sin_val (cor_sin)
	);

	ctyr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (den_q[DIV_W-1:0]),
		.done     (div_done),
		.overflow (div_ovf),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_lim_q <= 16'(AIRSPEED_LOW_RESET);
			hi_lim_q <= 16'(AIRSPEED_HIGH_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AIRSPEED_LOW:  lo_lim_q <= cfg_data;
				REG_AIRSPEED_HIGH: hi_lim_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			inv_q       <= 1'b0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						inv_q   <= 1'b0;
						fault_q <= 1'b0;
						if (!inputs_valid) begin
							state_q <= ST_DONE;
						end else if (roll_abs >= 18'(HALF_PI_Q13)) begin
							inv_q   <= 1'b1;
							state_q <= ST_DONE;
						end else if (v_clamp == 16'd0) begin
							fault_q <= 1'b1;
							held_q  <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ROLL;
						end
					end
				end
				ST_ROLL:  if (cor_done) state_q <= ST_PITCH;
				ST_PITCH: if (cor_done) state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_DIVGO;
				ST_DIVGO: begin
					if (den_q > 0) begin
						state_q <= ST_DIV;
					end else begin
						held_q  <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						held_q  <= sat_rate;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pa_q  <= pa;
			neg_q <= pitch_abs > 18'(HALF_PI_Q13);
			v_q   <= v_clamp;
		end
		if (state_q == ST_ROLL && cor_done) begin
			s_q  <= TRIG_W'(cor_sin >>> 14);
			cr_q <= TRIG_W'(cor_cos >>> 14);
		end
		if (state_q == ST_PITCH && cor_done) begin
			cp_q <= TRIG_W'(cp_full >>> 14);
		end
		if (state_q == ST_MUL1) begin
			prod_q <= PROD_W'(s_q) * PROD_W'(cp_q);
			den_q  <= (DEN_W'(cr_q) * DEN_W'($signed({1'b0, v_q}))) <<< 8;
		end
		if (state_q == ST_MUL2) begin
			num_q <= NUM_W'(prod_q) * NUM_W'(GRAV_Q16);
		end
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_rate_q  <= held_q;
			out_inv_q   <= inv_q;
			out_fault_q <= fault_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign yaw_rate_target = out_rate_q;
	assign inverted_flight = out_inv_q;
	assign rate_fault      = out_fault_q;

endmodule

### src/ctyr_cordic.sv
// Iterative rotation CORDIC: one micro-rotation per cycle, sixteen steps.
// Depends on ctyr_pkg for widths, gain and the arctangent table.
module ctyr_cordic import ctyr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [Z_W-1:0]  angle,
	output logic                   done,
	output logic signed [XY_W-1:0] cos_val,
	output logic signed [XY_W-1:0] sin_val
);

	logic                   busy_q, done_q;
	logic [STEP_W-1:0]      cnt_q;
	logic signed [XY_W-1:0] x_q, y_q, dx, dy;
	logic signed [Z_W-1:0]  z_q;

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= XY_W'(CORDIC_K_Q30);
			y_q <= '0;
			z_q <= angle;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_q16(cnt_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_q16(cnt_q);
			end
		end
	end

	assign done    = done_q;
	assign cos_val = x_q;
	assign sin_val = y_q;

endmodule

### src/ctyr_div.sv
// Restoring divider, one quotient bit per cycle, with an up-front check for
// quotients that do not fit in 32 bits. Depends on ctyr_pkg for widths.
module ctyr_div import ctyr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic             overflow,
	output logic [QUO_W-1:0] quotient
);

	localparam int CNT_W = $clog2(QUO_W);

	logic             busy_q, done_q, ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W:0]   rem_q, trial;
	logic [QUO_W-1:0] lo_q, quo_q;
	logic [DIV_W-1:0] dsr_q;
	logic             big;

	assign big   = {(DIV_W + QUO_W + 1 - DVD_W)'(0), dividend} >= {1'b0, divisor, QUO_W'(0)};
	assign trial = {rem_q[DIV_W-1:0], lo_q[QUO_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !big;
				done_q <= big;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= big;
			rem_q <= (DIV_W + 1)'(dividend >> QUO_W);
			lo_q  <= dividend[QUO_W-1:0];
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			lo_q <= {lo_q[QUO_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign overflow = ovf_q;
	assign quotient = quo_q;

endmodule
